// ----- rtl/shrl_pkg.sv -----
// Package for the sorted hash run lookup unit.
// Holds table geometry, stream field offsets, operation codes and the FSM type.
// No dependencies.
`default_nettype none

package shrl_pkg;

  localparam int ADDR_W      = 12;
  localparam int TABLE_DEPTH = 2 ** ADDR_W;
  localparam int LEN_W       = ADDR_W + 1;
  localparam int MAX_RUN     = 16;
  localparam int CNT_W       = $clog2(MAX_RUN + 1);

  localparam int HASH_W  = 64;
  localparam int ROW_W   = 32;
  localparam int LIMIT_W = 24;
  localparam int MEM_W   = HASH_W + ROW_W;

  // Input tdata layout, lowest bit first
  localparam int IDX_LSB   = 0;
  localparam int EHASH_LSB = IDX_LSB + ADDR_W;
  localparam int EROW_LSB  = EHASH_LSB + HASH_W;
  localparam int BASE_LSB  = EROW_LSB + ROW_W;
  localparam int LEN_LSB   = BASE_LSB + ADDR_W;
  localparam int QHASH_LSB = LEN_LSB + LEN_W;
  localparam int IN_BITS   = QHASH_LSB + HASH_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PROBE  = 6'b000010,
    S_CHECK  = 6'b000100,
    S_WREAD  = 6'b001000,
    S_WCHECK = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/sorted_hash_run_lookup_unit.sv -----
// Sorted hash run lookup unit: table store, leftmost binary search and run walk.
// Depends on shrl_pkg.
//
// Usage:
//   s_axis carries one operation per transfer. tuser 0 writes a (hash, row)
//   entry into the table slot given by entry_index; it gives no result. tuser 1
//   looks up query_hash in the sorted region (region_base, region_length), slot
//   addresses wrapping at the table end. m_axis returns the matching rows
//   below row_limit in table order, tlast on the final one; a miss gives one
//   transfer with found low. cfg_we/cfg_wdata write row_limit; write it only
//   while the unit is idle.
// Table reads:
//   Every table read goes through the single read port of the table memory
//   (address, then compare). A lookup makes at most ceil(log2(length + 1))
//   probes, 13 for a full table, then walks the matching run slots. One item
//   is in work at a time.
// Reset:
//   rst clears the control state, the output valid and row_limit. The
//   table contents are undefined until written; there is no clearing pass.
// Stall:
//   A result waits in the output register; one more found row is held back
//   internally, after which the walk holds until m_axis_tready frees a slot.
`default_nettype none

module sorted_hash_run_lookup_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // entry_index, entry_hash, entry_row, region_base, region_length, query_hash
  input  wire logic [shrl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // row_number
  output logic [shrl_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // found, truncated
  output logic [shrl_pkg::OUT_USER_W-1:0]      m_axis_tuser,
  output logic                                  m_axis_tlast,
  input  wire logic                             cfg_we,
  input  wire logic [shrl_pkg::LIMIT_W-1:0]    cfg_wdata
);

  shrl_pkg::state_t state;

  logic [shrl_pkg::MEM_W-1:0] mem [shrl_pkg::TABLE_DEPTH];
  logic [shrl_pkg::MEM_W-1:0] rd_data;
  logic                        rd_en;
  logic [shrl_pkg::ADDR_W-1:0] rd_addr;
  logic                        wr_en;

  logic [shrl_pkg::LIMIT_W-1:0] row_limit;
  logic [shrl_pkg::ADDR_W-1:0]  base;
  logic [shrl_pkg::LEN_W-1:0]   len;
  logic [shrl_pkg::HASH_W-1:0]  qhash;
  logic [shrl_pkg::LEN_W-1:0]   lo;
  logic [shrl_pkg::LEN_W-1:0]   hi_ex;
  logic [shrl_pkg::LEN_W-1:0]   mid;
  logic [shrl_pkg::LEN_W-1:0]   idx;
  logic                         hit;
  logic [shrl_pkg::CNT_W-1:0]   cnt;
  logic                         trunc;
  logic                         pend_valid;
  logic [shrl_pkg::LIMIT_W-1:0] pend_row;

  logic [shrl_pkg::LEN_W-1:0]  in_len;
  logic [shrl_pkg::LEN_W-1:0]  in_len_sat;
  logic [shrl_pkg::LEN_W-1:0]  probe_mid;
  logic [shrl_pkg::HASH_W-1:0] rd_hash;
  logic [shrl_pkg::ROW_W-1:0]  rd_row;
  logic [shrl_pkg::LEN_W-1:0]  lo_next;
  logic [shrl_pkg::LEN_W-1:0]  hi_ex_next;
  logic                        hit_next;
  logic                        row_ok;
  logic                        out_free;
  logic                        out_load;
  logic                        in_xfer;

  assign s_axis_tready = (state == shrl_pkg::S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign in_len     = s_axis_tdata[shrl_pkg::LEN_LSB +: shrl_pkg::LEN_W];
  assign in_len_sat = (in_len > shrl_pkg::LEN_W'(shrl_pkg::TABLE_DEPTH))
                    ? shrl_pkg::LEN_W'(shrl_pkg::TABLE_DEPTH) : in_len;

  assign probe_mid = shrl_pkg::LEN_W'(lo + ((hi_ex - lo - shrl_pkg::LEN_W'(1)) >> 1));

  assign rd_hash = rd_data[shrl_pkg::HASH_W-1:0];
  assign rd_row  = rd_data[shrl_pkg::MEM_W-1:shrl_pkg::HASH_W];
  assign row_ok  = rd_row < {{(shrl_pkg::ROW_W - shrl_pkg::LIMIT_W){1'b0}}, row_limit};

  always_comb begin
    lo_next    = lo;
    hi_ex_next = hi_ex;
    hit_next   = hit;
    if (rd_hash == qhash) begin
      hit_next   = 1'b1;
      hi_ex_next = mid;
    end else if (rd_hash < qhash) begin
      lo_next = mid + shrl_pkg::LEN_W'(1);
    end else begin
      hi_ex_next = mid;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = base + probe_mid[shrl_pkg::ADDR_W-1:0];
    if (state == shrl_pkg::S_PROBE) begin
      rd_en = 1'b1;
    end else if (state == shrl_pkg::S_WREAD) begin
      rd_en   = (idx < len);
      rd_addr = base + idx[shrl_pkg::ADDR_W-1:0];
    end
  end

  always_comb begin
    out_load = 1'b0;
    if (state == shrl_pkg::S_DONE) begin
      out_load = out_free;
    end else if (state == shrl_pkg::S_WCHECK) begin
      out_load = (rd_hash == qhash) && row_ok &&
                 (cnt != shrl_pkg::CNT_W'(shrl_pkg::MAX_RUN)) && pend_valid && out_free;
    end
  end

  assign wr_en = in_xfer && (s_axis_tuser == shrl_pkg::OP_WRITE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s_axis_tdata[shrl_pkg::IDX_LSB +: shrl_pkg::ADDR_W]] <=
        {s_axis_tdata[shrl_pkg::EROW_LSB +: shrl_pkg::ROW_W],
         s_axis_tdata[shrl_pkg::EHASH_LSB +: shrl_pkg::HASH_W]};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_limit <= '0;
    end else if (cfg_we) begin
      row_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= shrl_pkg::S_IDLE;
      pend_valid    <= 1'b0;
      hit           <= 1'b0;
      cnt           <= '0;
      trunc         <= 1'b0;
    end else begin
      case (state)
        shrl_pkg::S_IDLE: begin
          if (in_xfer && (s_axis_tuser == shrl_pkg::OP_LOOKUP)) begin
            base  <= s_axis_tdata[shrl_pkg::BASE_LSB +: shrl_pkg::ADDR_W];
            len   <= in_len_sat;
            qhash <= s_axis_tdata[shrl_pkg::QHASH_LSB +: shrl_pkg::HASH_W];
            lo    <= '0;
            hi_ex <= in_len_sat;
            hit   <= 1'b0;
            cnt   <= '0;
            trunc <= 1'b0;
            state <= (in_len_sat == '0) ? shrl_pkg::S_DONE : shrl_pkg::S_PROBE;
          end
        end
        shrl_pkg::S_PROBE: begin
          mid   <= probe_mid;
          state <= shrl_pkg::S_CHECK;
        end
        shrl_pkg::S_CHECK: begin
          lo    <= lo_next;
          hi_ex <= hi_ex_next;
          hit   <= hit_next;
          if (rd_hash == qhash) begin
            idx <= mid;
          end
          if (lo_next < hi_ex_next) begin
            state <= shrl_pkg::S_PROBE;
          end else if (hit_next) begin
            state <= shrl_pkg::S_WREAD;
          end else begin
            state <= shrl_pkg::S_DONE;
          end
        end
        shrl_pkg::S_WREAD: begin
          state <= (idx < len) ? shrl_pkg::S_WCHECK : shrl_pkg::S_DONE;
        end
        shrl_pkg::S_WCHECK: begin
          if (rd_hash != qhash) begin
            state <= shrl_pkg::S_DONE;
          end else if (!row_ok) begin
            idx   <= idx + shrl_pkg::LEN_W'(1);
            state <= shrl_pkg::S_WREAD;
          end else if (cnt == shrl_pkg::CNT_W'(shrl_pkg::MAX_RUN)) begin
            trunc <= 1'b1;
            state <= shrl_pkg::S_DONE;
          end else if (!pend_valid || out_free) begin
            if (pend_valid) begin
              m_axis_tdata  <= pend_row;
              m_axis_tuser  <= 2'b01;
              m_axis_tlast  <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_row   <= rd_row[shrl_pkg::LIMIT_W-1:0];
            cnt        <= cnt + shrl_pkg::CNT_W'(1);
            idx        <= idx + shrl_pkg::LEN_W'(1);
            state      <= shrl_pkg::S_WREAD;
          end
        end
        shrl_pkg::S_DONE: begin
          if (out_free) begin
            m_axis_tlast  <= 1'b1;
            if (pend_valid) begin
              m_axis_tdata <= pend_row;
              m_axis_tuser <= {trunc, 1'b1};
            end else begin
              m_axis_tdata <= '0;
              m_axis_tuser <= 2'b00;
            end
            pend_valid <= 1'b0;
            state      <= shrl_pkg::S_IDLE;
          end
        end
        default: begin
          state <= shrl_pkg::S_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= shrl_pkg::CNT_W'(shrl_pkg::MAX_RUN))
    else $error("run count above limit");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    (state == shrl_pkg::S_PROBE) |-> (lo < hi_ex))
    else $error("probe issued on empty search range");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == shrl_pkg::S_IDLE) |-> !pend_valid)
    else $error("held result left behind at idle");

  a_miss_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && !m_axis_tuser[1]))
    else $error("not-found result not final");

endmodule

`default_nettype wire

// ----- bench/sorted_hash_run_lookup_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sorted_hash_run_lookup_unit: fills table slots as lookups reach
// them, walks a directed script, then random sorted regions, checking against a local model.
// Depends on shrl_pkg and the unit RTL.

module sorted_hash_run_lookup_unit_tb;
  import shrl_pkg::*;

  localparam int IDLE_PCT       = 29;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 24;
  localparam int RANDOM_PHASES  = 4;
  localparam logic [HASH_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic                  found;
    logic [OUT_DATA_W-1:0] row;
    logic                  trunc;
    logic                  last;
  } lookup_result_t;

  typedef enum logic [1:0] {STEP_WRITE, STEP_RUN, STEP_LOOKUP, STEP_LIMIT} step_kind_t;

  typedef struct packed {
    step_kind_t          kind;
    logic [ADDR_W-1:0]   slot;
    logic [LEN_W-1:0]    count;
    logic [HASH_W-1:0]   hash;
    logic [ROW_W-1:0]    row;
    bit                  miss;
  } script_step_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = OP_WRITE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we        = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wdata     = '0;

  logic [HASH_W-1:0]  table_hash [TABLE_DEPTH];
  logic [ROW_W-1:0]   table_row  [TABLE_DEPTH];
  bit                 table_written [TABLE_DEPTH];
  logic [LIMIT_W-1:0] row_limit_model = '0;
  lookup_result_t     pending_results [$];
  script_step_t       script [$];

  bit quiet = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int writes_sent = 0;
  int lookups_sent = 0;
  int results_seen = 0;
  int truncations_seen = 0;
  int limit_settings = 0;
  int idle_cycles = 0;

  sorted_hash_run_lookup_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [HASH_W-1:0] preload_hash(int slot);
    return HASH_W'(slot >> 2) * 64'h003F_F000_0000_0011;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(logic [ADDR_W-1:0] idx,
      logic [HASH_W-1:0] ehash, logic [ROW_W-1:0] erow, logic [ADDR_W-1:0] base,
      logic [LEN_W-1:0] len, logic [HASH_W-1:0] qhash);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[IDX_LSB   +: ADDR_W] = idx;
    d[EHASH_LSB +: HASH_W] = ehash;
    d[EROW_LSB  +: ROW_W]  = erow;
    d[BASE_LSB  +: ADDR_W] = base;
    d[LEN_LSB   +: LEN_W]  = len;
    d[QHASH_LSB +: HASH_W] = qhash;
    return d;
  endfunction

  // first slot that the search or the run walk would read before it is written, else -1
  function automatic int first_unwritten(logic [ADDR_W-1:0] base, logic [LEN_W-1:0] len_in,
      logic [HASH_W-1:0] q);
    int len, lo, hi, mid, first_hit, i;
    bit hit;
    logic [ADDR_W-1:0] slot;
    len = (len_in > TABLE_DEPTH) ? TABLE_DEPTH : int'(len_in);
    hit = 1'b0;
    first_hit = 0;
    lo = 0;
    hi = len - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      slot = ADDR_W'(base + mid);
      if (!table_written[slot]) return int'(slot);
      if (table_hash[slot] == q) begin
        hit = 1'b1;
        first_hit = mid;
        hi = mid - 1;
      end else if (table_hash[slot] < q) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    if (hit) begin
      for (i = first_hit; i < len; i++) begin
        slot = ADDR_W'(base + i);
        if (!table_written[slot]) return int'(slot);
        if (table_hash[slot] != q) break;
      end
    end
    return -1;
  endfunction

  function automatic void predict_lookup(logic [ADDR_W-1:0] base, logic [LEN_W-1:0] len_in,
      logic [HASH_W-1:0] q);
    int len, lo, hi, mid, first_hit, i, k;
    bit hit, trunc;
    logic [ADDR_W-1:0] slot;
    logic [ROW_W-1:0] rows [$];
    lookup_result_t res;
    len = (len_in > TABLE_DEPTH) ? TABLE_DEPTH : int'(len_in);
    hit = 1'b0;
    trunc = 1'b0;
    first_hit = 0;
    lo = 0;
    hi = len - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      slot = ADDR_W'(base + mid);
      if (table_hash[slot] == q) begin
        hit = 1'b1;
        first_hit = mid;
        hi = mid - 1;
      end else if (table_hash[slot] < q) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    if (hit) begin
      for (i = first_hit; i < len; i++) begin
        slot = ADDR_W'(base + i);
        if (table_hash[slot] != q) break;
        if (table_row[slot] >= row_limit_model) continue;
        if (rows.size() >= MAX_RUN) begin
          trunc = 1'b1;
          break;
        end
        rows.push_back(table_row[slot]);
      end
    end
    res = '0;
    if (rows.size() == 0) begin
      res.last = 1'b1;
      pending_results.push_back(res);
    end else begin
      for (k = 0; k < rows.size(); k++) begin
        res.found = 1'b1;
        res.row   = rows[k][OUT_DATA_W-1:0];
        res.last  = (k == rows.size() - 1);
        res.trunc = res.last && trunc;
        pending_results.push_back(res);
      end
    end
  endfunction

  task automatic send_item(input logic op, input logic [ADDR_W-1:0] idx,
      input logic [HASH_W-1:0] ehash, input logic [ROW_W-1:0] erow,
      input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] len,
      input logic [HASH_W-1:0] qhash, input bit want_miss);
    lookup_result_t miss_res;
    while (!quiet && $urandom_range(99, 0) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= pack_item(idx, ehash, erow, base, len, qhash);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    if (op == OP_WRITE) begin
      table_hash[idx]    = ehash;
      table_row[idx]     = erow;
      table_written[idx] = 1'b1;
      writes_sent++;
    end else begin
      lookups_sent++;
      if (want_miss) begin
        miss_res = '0;
        miss_res.last = 1'b1;
        pending_results.push_back(miss_res);
      end else begin
        predict_lookup(base, len, qhash);
      end
    end
  endtask

  task automatic write_slot(input logic [ADDR_W-1:0] idx, input logic [HASH_W-1:0] h,
      input logic [ROW_W-1:0] r);
    send_item(OP_WRITE, idx, h, r, ADDR_W'($urandom()), LEN_W'($urandom()),
              {$urandom(), $urandom()}, 1'b0);
  endtask

  // fill every slot the lookup will read with the ascending table first
  task automatic lookup(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] len,
      input logic [HASH_W-1:0] q, input bit want_miss);
    int gap;
    gap = first_unwritten(base, len, q);
    while (gap >= 0) begin
      write_slot(ADDR_W'(gap), preload_hash(gap), ROW_W'(gap));
      gap = first_unwritten(base, len, q);
    end
    send_item(OP_LOOKUP, ADDR_W'($urandom()), {$urandom(), $urandom()}, $urandom(),
              base, len, q, want_miss);
  endtask

  // hold the sender until the unit has returned everything and gone idle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_row_limit(input logic [LIMIT_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    row_limit_model = value;
    limit_settings++;
  endtask

  task automatic add_step(input step_kind_t kind, input logic [ADDR_W-1:0] slot,
      input logic [LEN_W-1:0] count, input logic [HASH_W-1:0] hash,
      input logic [ROW_W-1:0] row, input bit miss);
    script_step_t st;
    st.kind  = kind;
    st.slot  = slot;
    st.count = count;
    st.hash  = hash;
    st.row   = row;
    st.miss  = miss;
    script.push_back(st);
  endtask

  task automatic run_region();
    logic [ADDR_W-1:0] base;
    logic [HASH_W-1:0] h, q;
    logic [ROW_W-1:0]  r;
    logic [HASH_W-1:0] run_hashes [$];
    logic [HASH_W-1:0] slot_hashes [$];
    logic [ROW_W-1:0]  slot_rows [$];
    int n_runs, run_len, total, n_lookups, off, len, pick, j, k;
    bit shuffled;
    base = ADDR_W'($urandom());
    n_runs = $urandom_range(3, 1);
    shuffled = ($urandom_range(7, 0) == 0);
    h = {$urandom(), $urandom()};
    if ($urandom_range(5, 0) == 0) h = '0;
    if (h > ALL_ONES - 64'd1024) h = h - 64'd1024;
    for (k = 0; k < n_runs; k++) begin
      run_len = ($urandom_range(5, 0) == 0) ? $urandom_range(20, 17) : $urandom_range(4, 1);
      r = ($urandom_range(3, 0) == 0) ? $urandom_range(24'hFFFF00, 0) : $urandom_range(40, 0);
      for (j = 0; j < run_len; j++) begin
        if ($urandom_range(9, 0) == 0) r = r | {8'($urandom_range(255, 1)), 24'h0};
        slot_hashes.push_back(h);
        slot_rows.push_back(r);
        r = r + $urandom_range(3, 0);
      end
      run_hashes.push_back(h);
      h = h + $urandom_range(255, 1);
    end
    total = slot_hashes.size();
    if (shuffled)
      foreach (slot_hashes[i]) slot_hashes[i] = run_hashes[$urandom_range(n_runs - 1, 0)];
    foreach (slot_hashes[i]) write_slot(ADDR_W'(base + i), slot_hashes[i], slot_rows[i]);
    n_lookups = $urandom_range(5, 2);
    for (k = 0; k < n_lookups; k++) begin
      pick = $urandom_range(9, 0);
      q = run_hashes[$urandom_range(n_runs - 1, 0)];
      off = 0;
      len = total;
      if (pick == 6) begin
        off = $urandom_range(total - 1, 0);
        len = $urandom_range(total - off, 1);
      end else if (pick == 7) begin
        len = $urandom_range(8191, total);
      end else if (pick == 8) begin
        q = $urandom_range(1, 0) ? q + 1 : q - 1;
      end
      if (pick == 9)
        lookup(ADDR_W'($urandom()), LEN_W'($urandom()), {$urandom(), $urandom()}, 1'b0);
      else
        lookup(ADDR_W'(base + off), LEN_W'(len), q, 1'b0);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_result();
    lookup_result_t want;
    results_seen++;
    if (m_axis_tuser[1]) truncations_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch("result with none pending", m_axis_tdata, 0);
    end else begin
      want = pending_results.pop_front();
      if (m_axis_tuser[0] !== want.found) report_mismatch("found", m_axis_tuser[0], want.found);
      if (m_axis_tdata !== want.row) report_mismatch("row_number", m_axis_tdata, want.row);
      if (m_axis_tuser[1] !== want.trunc)
        report_mismatch("truncated", m_axis_tuser[1], want.trunc);
      if (m_axis_tlast !== want.last) report_mismatch("last", m_axis_tlast, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("** sorted_hash_run_lookup_unit: FAILED **");
        $finish;
      end else begin
        if (m_axis_tvalid && m_axis_tready) check_result();
        m_axis_tready <= quiet || ($urandom_range(99, 0) >= IDLE_PCT);
      end
    end
  end

  initial begin
    logic [LIMIT_W-1:0] phase_limit;
    int phase, phase_start, k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_step(STEP_LOOKUP, 12'd0,    13'd4096, preload_hash(0),    '0, 1'b1);
    add_step(STEP_LOOKUP, 12'd7,    13'd0,    preload_hash(7),    '0, 1'b1);
    add_step(STEP_WRITE,  12'd4095, '0,       preload_hash(4095), 32'hFFFF_FFFF, 1'b0);
    add_step(STEP_LIMIT,  '0,       '0,       '0,                 32'h00FF_FFFF, 1'b0);
    add_step(STEP_LOOKUP, 12'd0,    13'd8191, preload_hash(4095), '0, 1'b0);
    add_step(STEP_LOOKUP, 12'd0,    13'd4097, preload_hash(0),    '0, 1'b0);
    add_step(STEP_LOOKUP, 12'd0,    13'd4096, ALL_ONES,           '0, 1'b1);
    add_step(STEP_LOOKUP, 12'd0,    13'd4096, 64'd1,              '0, 1'b0);
    add_step(STEP_RUN,    12'd4084, 13'd18,   ALL_ONES,           '0, 1'b0);
    add_step(STEP_LOOKUP, 12'd4084, 13'd18,   ALL_ONES,           '0, 1'b0);
    add_step(STEP_LOOKUP, 12'd4084, 13'd17,   ALL_ONES,           '0, 1'b0);
    add_step(STEP_LOOKUP, 12'd4084, 13'd16,   ALL_ONES,           '0, 1'b0);
    add_step(STEP_WRITE,  12'd4083, '0,       ALL_ONES,           32'hFFFF_FFFF, 1'b0);
    add_step(STEP_LOOKUP, 12'd4083, 13'd19,   ALL_ONES,           '0, 1'b0);
    add_step(STEP_LIMIT,  '0,       '0,       '0,                 32'd10, 1'b0);
    add_step(STEP_LOOKUP, 12'd4084, 13'd18,   ALL_ONES,           '0, 1'b0);
    add_step(STEP_LOOKUP, 12'd0,    13'd4096, preload_hash(0),    '0, 1'b0);
    add_step(STEP_LIMIT,  '0,       '0,       '0,                 32'd1, 1'b0);
    add_step(STEP_LOOKUP, 12'd4084, 13'd18,   ALL_ONES,           '0, 1'b0);
    add_step(STEP_WRITE,  12'd0,    '0,       '0,                 '0, 1'b0);
    add_step(STEP_LOOKUP, 12'd4084, 13'd18,   ALL_ONES,           '0, 1'b0);

    foreach (script[s]) begin
      case (script[s].kind)
        STEP_WRITE: write_slot(script[s].slot, script[s].hash, script[s].row);
        STEP_RUN: begin
          for (k = 0; k < script[s].count; k++)
            write_slot(ADDR_W'(script[s].slot + k), script[s].hash, script[s].row + k);
        end
        STEP_LOOKUP: lookup(script[s].slot, script[s].count, script[s].hash, script[s].miss);
        default: set_row_limit(script[s].row[LIMIT_W-1:0]);
      endcase
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: phase_limit = $urandom_range(64, 16);
        1: phase_limit = '1;
        2: phase_limit = $urandom_range(8, 1);
        default: phase_limit = LIMIT_W'($urandom());
      endcase
      set_row_limit(phase_limit);
      quiet = (phase == 1);
      phase_start = items_sent;
      while (items_sent - phase_start < RANDOM_ITEMS / RANDOM_PHASES) run_region();
    end
    quiet = 1'b0;

    drain();
    repeat (48) @(posedge clk);
    $display("Covered %0d table writes and %0d lookups over %0d row limit settings.",
             writes_sent, lookups_sent, limit_settings);
    $display("Checked %0d result transfers, %0d of them truncated; %0d mismatches.",
             results_seen, truncations_seen, errors);
    if (errors == 0 && pending_results.size() == 0)
      $display("** sorted_hash_run_lookup_unit: PASSED **");
    else
      $display("** sorted_hash_run_lookup_unit: FAILED **");
    $finish;
  end

endmodule
